FILE: design/size_budget_lru_block_cache_macros.svh
// assertion macros for the size budget lru block cache checker
// used by the checker file only; no other dependencies
`ifndef SIZE_BUDGET_LRU_BLOCK_CACHE_MACROS_SVH
`define SIZE_BUDGET_LRU_BLOCK_CACHE_MACROS_SVH

// same-cycle implication
`define SBLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SBLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: design/sblc_pkg.sv
// types and codes shared by the cache cells and the cache top level
// no dependencies
`default_nettype none
package sblc_pkg;

	localparam int FILE_W   = 16;
	localparam int OFFSET_W = 48;
	localparam int SIZE_W   = 17;
	localparam int HANDLE_W = 32;
	localparam int CAP_W    = 32;
	localparam int USED_W   = 33;
	localparam int STAT_W   = 32;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_INVAL  = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PROMOTE,
		CELL_PUSH,
		CELL_REMOVE,
		CELL_DROP_LAST,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		logic                valid;
		logic [FILE_W-1:0]   file;
		logic [OFFSET_W-1:0] offset;
		logic [SIZE_W-1:0]   size;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		cell_op_t            op;
		logic                file_only;
		logic [FILE_W-1:0]   file;
		logic [OFFSET_W-1:0] offset;
	} cell_cmd_t;

	typedef struct packed {
		logic first;
		logic last;
	} cell_stat_t;

endpackage
`default_nettype wire

FILE: design/sblc_cell.sv
// one entry of the recency-ordered tag chain; position in the chain is the rank
// depends on sblc_pkg
`default_nettype none
module sblc_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sblc_pkg::cell_cmd_t  cmd,
	input  sblc_pkg::entry_t     prev,
	input  sblc_pkg::entry_t     next,
	input  wire                  pre_in,
	output logic                 pre_out,
	output sblc_pkg::entry_t     own,
	output sblc_pkg::cell_stat_t stat
);
	import sblc_pkg::*;

	logic   valid_q;
	entry_t data_q;
	logic   match;
	logic   take_prev;
	logic   take_next;
	logic   kill;

	always_comb begin
		own       = data_q;
		own.valid = valid_q;
	end

	assign match   = valid_q && data_q.file == cmd.file &&
		(cmd.file_only || data_q.offset == cmd.offset);
	assign pre_out = pre_in | match;
	assign stat.first = match & ~pre_in;
	assign stat.last  = valid_q & ~next.valid;

	always_comb begin
		take_prev = 1'b0;
		take_next = 1'b0;
		kill      = 1'b0;
		case (cmd.op)
			CELL_PROMOTE:   take_prev = ~pre_in;
			CELL_PUSH:      take_prev = 1'b1;
			CELL_REMOVE:    take_next = pre_out;
			CELL_DROP_LAST: kill = stat.last;
			CELL_CLEAR:     kill = 1'b1;
			default:        ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (kill) begin
			valid_q <= 1'b0;
		end else if (take_prev) begin
			valid_q <= prev.valid;
		end else if (take_next) begin
			valid_q <= next.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_prev) begin
			data_q <= prev;
		end else if (take_next) begin
			data_q <= next;
		end
	end
endmodule
`default_nettype wire

FILE: design/size_budget_lru_block_cache.sv
// size budgeted lru tag store: a lookup, an insert of a present key or of size zero, and a clear
// finish in the exec step; an insert of a new key then drops tail entries while over budget or
// full and pushes the new one; an invalidate removes matching entries of the file one per step.
// one item at a time, the next is accepted in the cycle after the result loads; the recency chain
// moves by a single shift step per cycle. a full output register holds the item in its
// last step. reset empties the chain and clears all counters at once.
`default_nettype none
module size_budget_lru_block_cache #(
	parameter int ENTRIES         = 64,
	parameter int MAX_BLOCK_BYTES = 65536
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [sblc_pkg::CAP_W-1:0]      capacity_bytes,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [1:0]                      opcode,
	input  wire  [sblc_pkg::FILE_W-1:0]     file_id,
	input  wire  [sblc_pkg::OFFSET_W-1:0]   blk_offset,
	input  wire  [sblc_pkg::SIZE_W-1:0]     blk_bytes,
	input  wire  [sblc_pkg::HANDLE_W-1:0]   block_handle,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic                            hit,
	output logic [sblc_pkg::HANDLE_W-1:0]   handle_out,
	output logic [sblc_pkg::STAT_W-1:0]     hit_count,
	output logic [sblc_pkg::STAT_W-1:0]     miss_count,
	output logic [sblc_pkg::USED_W-1:0]     used_bytes,
	output logic [$clog2(ENTRIES + 1)-1:0]  entry_count
);
	import sblc_pkg::*;

	localparam int CW       = $clog2(ENTRIES + 1);
	localparam int SZ_CMP_W = 22;
	localparam logic [SZ_CMP_W-1:0] MAX_BLK = SZ_CMP_W'(MAX_BLOCK_BYTES);

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_EVICT, S_INVAL, S_DONE} state_t;

	state_t              state_q;
	opcode_t             op_q;
	logic [FILE_W-1:0]   file_q;
	logic [OFFSET_W-1:0] off_q;
	logic [SIZE_W-1:0]   size_q;
	logic [HANDLE_W-1:0] hnd_q;
	logic [CAP_W-1:0]    cap_q;
	logic [USED_W-1:0]   bytes_q;
	logic [CW-1:0]       count_q;
	logic [STAT_W-1:0]   hits_q;
	logic [STAT_W-1:0]   miss_q;
	logic                res_hit_q;
	logic [HANDLE_W-1:0] res_hnd_q;
	logic                out_valid_q;
	logic                hit_q;
	logic [HANDLE_W-1:0] handle_out_q;
	logic [STAT_W-1:0]   hit_count_q;
	logic [STAT_W-1:0]   miss_count_q;
	logic [USED_W-1:0]   used_q;
	logic [CW-1:0]       entry_count_q;

	cell_cmd_t  cmd;
	entry_t     head;
	entry_t     ents [ENTRIES];
	cell_stat_t stats [ENTRIES];
	logic [ENTRIES:0] pre;

	logic                any_sel;
	logic [SIZE_W-1:0]   sel_size;
	logic [HANDLE_W-1:0] sel_hnd;
	logic [SIZE_W-1:0]   last_size;
	logic                over;
	logic                full;
	logic                res_load;
	logic [USED_W:0]     budget_sum;
	logic [SIZE_W-1:0]   in_size_sat;

	function automatic logic [USED_W-1:0] sub_floor(input logic [USED_W-1:0] a,
		input logic [SIZE_W-1:0] b);
		logic [USED_W-1:0] bx;
		bx = USED_W'(b);
		return (a >= bx) ? a - bx : '0;
	endfunction

	function automatic logic [USED_W-1:0] add_sat(input logic [USED_W-1:0] a,
		input logic [SIZE_W-1:0] b);
		logic [USED_W:0] s;
		s = {1'b0, a} + (USED_W + 1)'(b);
		return s[USED_W] ? '1 : s[USED_W-1:0];
	endfunction

	assign pre[0] = 1'b0;

	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		entry_t nb_prev;
		entry_t nb_next;
		if (k == 0) begin : g_first
			assign nb_prev = head;
		end else begin : g_mid
			assign nb_prev = ents[k-1];
		end
		if (k == ENTRIES - 1) begin : g_end
			assign nb_next = '0;
		end else begin : g_inner
			assign nb_next = ents[k+1];
		end
		sblc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.prev    (nb_prev),
			.next    (nb_next),
			.pre_in  (pre[k]),
			.pre_out (pre[k+1]),
			.own     (ents[k]),
			.stat    (stats[k])
		);
	end

	// one-hot picks from the chain: first match and tail entry
	always_comb begin
		sel_size  = '0;
		sel_hnd   = '0;
		last_size = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			sel_size  = sel_size  | (stats[k].first ? ents[k].size : '0);
			sel_hnd   = sel_hnd   | (stats[k].first ? ents[k].handle : '0);
			last_size = last_size | (stats[k].last ? ents[k].size : '0);
		end
	end
	assign any_sel = pre[ENTRIES];

	assign budget_sum = {1'b0, bytes_q} + (USED_W + 1)'(size_q);
	assign over = (count_q != '0) && (budget_sum > (USED_W + 1)'(cap_q));
	assign full = (count_q == CW'(ENTRIES));
	assign in_size_sat = ((SZ_CMP_W)'(blk_bytes) > MAX_BLK) ? SIZE_W'(MAX_BLK) : blk_bytes;
	assign res_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		head.valid  = 1'b1;
		head.file   = file_q;
		head.offset = off_q;
		head.size   = (op_q == OP_LOOKUP) ? sel_size : size_q;
		head.handle = (op_q == OP_LOOKUP) ? sel_hnd : hnd_q;
		cmd.op        = CELL_HOLD;
		cmd.file_only = (state_q == S_INVAL);
		cmd.file      = file_q;
		cmd.offset    = off_q;
		case (state_q)
			S_EXEC: begin
				case (op_q)
					OP_LOOKUP: if (any_sel) cmd.op = CELL_PROMOTE;
					OP_INSERT: if (size_q != '0 && any_sel) cmd.op = CELL_PROMOTE;
					OP_CLEAR:  cmd.op = CELL_CLEAR;
					default:   ;
				endcase
			end
			S_EVICT: cmd.op = (over || full) ? CELL_DROP_LAST : CELL_PUSH;
			S_INVAL: if (any_sel) cmd.op = CELL_REMOVE;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(8388608);
		end else if (cfg_valid) begin
			cap_q <= capacity_bytes;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q   <= opcode_t'(opcode);
			file_q <= file_id;
			off_q  <= blk_offset;
			size_q <= in_size_sat;
			hnd_q  <= block_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			bytes_q       <= '0;
			count_q       <= '0;
			hits_q        <= '0;
			miss_q        <= '0;
			res_hit_q     <= 1'b0;
			res_hnd_q     <= '0;
			out_valid_q   <= 1'b0;
			hit_q         <= 1'b0;
			handle_out_q  <= '0;
			hit_count_q   <= '0;
			miss_count_q  <= '0;
			used_q        <= '0;
			entry_count_q <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					res_hit_q <= 1'b0;
					res_hnd_q <= '0;
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q)
						OP_LOOKUP: begin
							state_q <= S_DONE;
							if (any_sel) begin
								res_hit_q <= 1'b1;
								res_hnd_q <= sel_hnd;
								if (hits_q != '1) hits_q <= hits_q + 1'b1;
							end else if (miss_q != '1) begin
								miss_q <= miss_q + 1'b1;
							end
						end
						OP_INSERT: begin
							if (size_q != '0 && !any_sel) begin
								state_q <= S_EVICT;
							end else begin
								state_q <= S_DONE;
							end
							if (size_q != '0 && any_sel) begin
								bytes_q <= add_sat(sub_floor(bytes_q, sel_size), size_q);
							end
						end
						OP_INVAL: state_q <= S_INVAL;
						OP_CLEAR: begin
							state_q <= S_DONE;
							bytes_q <= '0;
							count_q <= '0;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_EVICT: begin
					if (over || full) begin
						bytes_q <= sub_floor(bytes_q, last_size);
						count_q <= count_q - 1'b1;
					end else begin
						bytes_q <= add_sat(bytes_q, size_q);
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_INVAL: begin
					if (any_sel) begin
						bytes_q <= sub_floor(bytes_q, sel_size);
						count_q <= count_q - 1'b1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						hit_q         <= res_hit_q;
						handle_out_q  <= res_hnd_q;
						hit_count_q   <= hits_q;
						miss_count_q  <= miss_q;
						used_q        <= bytes_q;
						entry_count_q <= count_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign handle_out  = handle_out_q;
	assign hit_count   = hit_count_q;
	assign miss_count  = miss_count_q;
	assign used_bytes  = used_q;
	assign entry_count = entry_count_q;
endmodule
`default_nettype wire

FILE: design/sblc_checker.sv
// port-level checks for the cache top level, attached by bind
// depends on sblc_pkg and the macros header
`default_nettype none
`include "size_budget_lru_block_cache_macros.svh"
module sblc_checker #(
	parameter int ENTRIES = 64,
	parameter int CW      = $clog2(ENTRIES + 1)
) (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           out_valid,
	input wire                           out_ready,
	input wire                           hit,
	input wire [sblc_pkg::HANDLE_W-1:0]  handle_out,
	input wire [sblc_pkg::STAT_W-1:0]    hit_count,
	input wire [sblc_pkg::STAT_W-1:0]    miss_count,
	input wire [CW-1:0]                  entry_count
);
	import sblc_pkg::*;

	`SBLC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(hit_count) && $stable(entry_count))
	`SBLC_ASSERT_NOW(a_miss_zero_handle, clk, arst_n, out_valid && !hit, handle_out == '0)
	`SBLC_ASSERT_NOW(a_count_bound, clk, arst_n, out_valid, entry_count <= CW'(ENTRIES))
	`SBLC_ASSERT_NEXT(a_stats_grow, clk, arst_n, out_valid && out_ready,
		hit_count >= $past(hit_count) && miss_count >= $past(miss_count))
endmodule

bind size_budget_lru_block_cache sblc_checker #(
	.ENTRIES (ENTRIES),
	.CW      (CW)
) u_sblc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.hit         (hit),
	.handle_out  (handle_out),
	.hit_count   (hit_count),
	.miss_count  (miss_count),
	.entry_count (entry_count)
);
`default_nettype wire
